[hw/rtl/bfsp_pkg.sv]
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants of the bit-field stack packer.
// ----------------------------------------------------------------------------
package bfsp_pkg;

   // field widths of the request and response words
   localparam int REQ_W     = 3;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 6;
   localparam int INDEX_W   = 8;
   localparam int BYTE_W    = 8;
   localparam int POINTER_W = 12;

   // longest field a push or pop may carry
   localparam int MAX_FIELD_BITS = 32;

   // a field at any bit offset spans at most this many bytes
   localparam int WIN_BYTES = (MAX_FIELD_BITS + 14) / 8;
   localparam int WIN_W     = WIN_BYTES * 8;

   // byte address carried in a command, wide enough for the largest buffer
   localparam int ADDR_MAX_W = 16;

   localparam int QUEUE_DEPTH = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_PUSH        = 3'd0;
   localparam logic [REQ_W-1:0] REQ_POP         = 3'd1;
   localparam logic [REQ_W-1:0] REQ_WRITE_BYTE  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_READ_BYTE   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SET_POINTER = 3'd4;

   // command codes passed from front to back
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] CMD_NONE  = 3'd0;
   localparam logic [OP_W-1:0] CMD_PUSH  = 3'd1;
   localparam logic [OP_W-1:0] CMD_POP   = 3'd2;
   localparam logic [OP_W-1:0] CMD_WRITE = 3'd3;
   localparam logic [OP_W-1:0] CMD_READ  = 3'd4;

   typedef struct packed {
      logic [REQ_W-1:0]     req_type;
      logic [VALUE_W-1:0]   field_value;
      logic [COUNT_W-1:0]   bit_count;
      logic [INDEX_W-1:0]   byte_index;
      logic [BYTE_W-1:0]    byte_in;
      logic [POINTER_W-1:0] new_pointer;
   } request_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   popped_value;
      logic [BYTE_W-1:0]    byte_out;
      logic [POINTER_W-1:0] pointer_now;
      logic                 error;
   } response_type;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [ADDR_MAX_W-1:0] addr;        // first byte touched
      logic [2:0]            offset;      // bit offset of the field in that byte
      logic [COUNT_W-1:0]    count;
      logic [VALUE_W-1:0]    value;
      logic [BYTE_W-1:0]     byte_data;
      logic [POINTER_W-1:0]  pointer_now;
      logic                  error;
   } command_type;

endpackage

[hw/rtl/bfsp_ram.sv]
// ----------------------------------------------------------------------------
// bfsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bfsp_queue.sv]
// ----------------------------------------------------------------------------
// bfsp_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bfsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  bfsp_pkg::command_type wr_data,
   output logic                  full,
   output logic                  rd_valid,
   input  logic                  rd_en,
   output bfsp_pkg::command_type rd_data
);

   localparam int DEPTH = bfsp_pkg::QUEUE_DEPTH;
   localparam int QW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   bfsp_pkg::command_type slot_ff [DEPTH];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QW'(DEPTH - 1)) ? '0 : wr_ptr_ff + QW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QW'(DEPTH - 1)) ? '0 : rd_ptr_ff + QW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign full     = (count_ff == CW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];

endmodule

[hw/rtl/bfsp_front.sv]
// ----------------------------------------------------------------------------
// bfsp_front
// Takes requests, checks them against the bit pointer and queues commands.
// ----------------------------------------------------------------------------
module bfsp_front #(
   parameter int BUF_BYTES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bfsp_pkg::request_type req_data,
   input  logic                  clearing,
   input  logic                  q_full,
   output logic                  q_wr,
   output bfsp_pkg::command_type q_wr_data
);

   localparam int CAP_BITS = BUF_BYTES * 8;
   localparam int PW       = $clog2(CAP_BITS + 1);
   localparam int SW       = PW + 1;
   localparam logic [PW-1:0] CAP = PW'(CAP_BITS);

   logic [PW-1:0] ptr_ff, ptr_in;
   logic [PW-1:0] pop_start;
   logic accept;
   logic count_bad, push_err, pop_err, index_err, pointer_err;
   bfsp_pkg::command_type cmd;

   assign busy   = q_full || clearing;
   assign accept = start && !busy;

   assign count_bad   = (req_data.bit_count == '0) ||
                        (int'(req_data.bit_count) > bfsp_pkg::MAX_FIELD_BITS);
   assign push_err    = count_bad ||
                        ((SW'(ptr_ff) + SW'(req_data.bit_count)) > SW'(CAP));
   assign pop_err     = count_bad || (SW'(req_data.bit_count) > SW'(ptr_ff));
   assign index_err   = int'(req_data.byte_index) >= BUF_BYTES;
   assign pointer_err = int'(req_data.new_pointer) > CAP_BITS;
   assign pop_start   = ptr_ff - PW'(req_data.bit_count);

   always_comb begin
      ptr_in        = ptr_ff;
      cmd.op        = bfsp_pkg::CMD_NONE;
      cmd.addr      = bfsp_pkg::ADDR_MAX_W'(req_data.byte_index);
      cmd.offset    = '0;
      cmd.count     = req_data.bit_count;
      cmd.value     = req_data.field_value;
      cmd.byte_data = req_data.byte_in;
      cmd.error     = 1'b0;
      unique case (req_data.req_type)
         bfsp_pkg::REQ_PUSH: begin
            if (push_err) begin
               cmd.error = 1'b1;
            end else begin
               cmd.op     = bfsp_pkg::CMD_PUSH;
               cmd.addr   = bfsp_pkg::ADDR_MAX_W'(ptr_ff >> 3);
               cmd.offset = ptr_ff[2:0];
               ptr_in     = ptr_ff + PW'(req_data.bit_count);
            end
         end
         bfsp_pkg::REQ_POP: begin
            if (pop_err) begin
               cmd.error = 1'b1;
            end else begin
               cmd.op     = bfsp_pkg::CMD_POP;
               cmd.addr   = bfsp_pkg::ADDR_MAX_W'(pop_start >> 3);
               cmd.offset = pop_start[2:0];
               ptr_in     = pop_start;
            end
         end
         bfsp_pkg::REQ_WRITE_BYTE: begin
            if (index_err) begin
               cmd.error = 1'b1;
            end else begin
               cmd.op = bfsp_pkg::CMD_WRITE;
            end
         end
         bfsp_pkg::REQ_READ_BYTE: begin
            if (index_err) begin
               cmd.error = 1'b1;
            end else begin
               cmd.op = bfsp_pkg::CMD_READ;
            end
         end
         bfsp_pkg::REQ_SET_POINTER: begin
            if (pointer_err) begin
               cmd.error = 1'b1;
            end else begin
               ptr_in = PW'(req_data.new_pointer);
            end
         end
         default: begin
            // undefined request: plain echo of the pointer
         end
      endcase
      cmd.pointer_now = bfsp_pkg::POINTER_W'(ptr_in);
   end

   assign q_wr      = accept;
   assign q_wr_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (accept) begin
         ptr_ff <= ptr_in;
      end
   end

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= CAP)
      else $error("bit pointer beyond buffer");

   a_refused_keeps_ptr: assert property (@(posedge clock) disable iff (reset)
      accept && cmd.error |=> $stable(ptr_ff))
      else $error("refused request moved the pointer");

endmodule

[hw/rtl/bfsp_back.sv]
// ----------------------------------------------------------------------------
// bfsp_back
// Executes queued commands on the byte buffer and drives the response.
// ----------------------------------------------------------------------------
module bfsp_back #(
   parameter int BUF_BYTES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  bfsp_pkg::command_type  q_data,
   output logic                   q_rd,
   output logic                   clearing,
   output logic                   rsp_valid,
   output bfsp_pkg::response_type rsp_data
);

   localparam int AW    = $clog2(BUF_BYTES);
   localparam int WIN_W = bfsp_pkg::WIN_W;
   localparam int CW    = $clog2(bfsp_pkg::WIN_BYTES + 1);
   localparam int SUMW  = $clog2(WIN_W + 1) + 1;
   localparam int BW    = bfsp_pkg::BYTE_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MERGE = 3'd2;
   localparam logic [2:0] ST_PUSH  = 3'd3;
   localparam logic [2:0] ST_POP   = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [WIN_W-1:0] win_ff, win_in;
   logic [WIN_W-1:0] msk_ff, msk_in;
   logic [WIN_W-1:0] acc_ff, acc_in;
   logic [CW-1:0]    nbytes_ff, nbytes_in;
   logic [CW-1:0]    issued_ff, issued_in;
   logic [CW-1:0]    got_ff, got_in;
   logic [2:0]       tail_ff, tail_in;
   logic [bfsp_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [bfsp_pkg::POINTER_W-1:0] ptr_now_ff, ptr_now_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bfsp_pkg::response_type rsp_data_ff, rsp_data_in;

   // decode of the queue head
   logic [AW-1:0]    head_addr;
   logic [SUMW-1:0]  head_sum;
   logic [SUMW-1:0]  head_shift;
   logic [WIN_W-1:0] head_lowmask;
   logic [WIN_W-1:0] head_win;
   logic [WIN_W-1:0] head_msk;
   logic [CW-1:0]    head_nbytes;
   logic [2:0]       head_tail;

   logic [WIN_W-1:0] acc_next;
   logic [WIN_W-1:0] pop_mask;
   logic [BW-1:0]    win_top, msk_top;

   logic           ram_wr_en, ram_rd_en;
   logic [AW-1:0]  ram_wr_addr, ram_rd_addr;
   logic [BW-1:0]  ram_wr_data, ram_rd_data;

   bfsp_ram #(
      .WIDTH (BW),
      .DEPTH (BUF_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign head_addr    = AW'(q_data.addr);
   assign head_sum     = SUMW'(q_data.offset) + SUMW'(q_data.count);
   assign head_shift   = SUMW'(WIN_W) - head_sum;
   assign head_nbytes  = CW'((head_sum + SUMW'(7)) >> 3);
   assign head_tail    = 3'(SUMW'(0) - head_sum);
   assign head_lowmask = (WIN_W'(1) << q_data.count) - WIN_W'(1);
   assign head_win     = (WIN_W'(q_data.value) & head_lowmask) << head_shift;
   assign head_msk     = head_lowmask << head_shift;

   assign acc_next = {acc_ff[WIN_W-BW-1:0], ram_rd_data};
   assign pop_mask = (WIN_W'(1) << count_ff) - WIN_W'(1);
   assign win_top  = win_ff[WIN_W-1 -: BW];
   assign msk_top  = msk_ff[WIN_W-1 -: BW];

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      base_in      = base_ff;
      win_in       = win_ff;
      msk_in       = msk_ff;
      acc_in       = acc_ff;
      nbytes_in    = nbytes_ff;
      issued_in    = issued_ff;
      got_in       = got_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      ptr_now_in   = ptr_now_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      q_rd         = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = base_ff + AW'(issued_ff);
      ram_wr_data  = win_top & msk_top;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = base_ff + AW'(issued_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(BUF_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_rd       = 1'b1;
               ptr_now_in = q_data.pointer_now;
               base_in    = head_addr;
               unique case (q_data.op)
                  bfsp_pkg::CMD_PUSH: begin
                     win_in    = head_win;
                     msk_in    = head_msk;
                     nbytes_in = head_nbytes;
                     issued_in = '0;
                     if (q_data.offset != '0) begin
                        // byte already begun: fetch it to keep its leading bits
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_addr;
                        state_in    = ST_MERGE;
                     end else begin
                        state_in = ST_PUSH;
                     end
                  end
                  bfsp_pkg::CMD_POP: begin
                     nbytes_in   = head_nbytes;
                     tail_in     = head_tail;
                     count_in    = q_data.count;
                     acc_in      = '0;
                     got_in      = '0;
                     issued_in   = CW'(1);
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head_addr;
                     state_in    = ST_POP;
                  end
                  bfsp_pkg::CMD_WRITE: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = head_addr;
                     ram_wr_data = q_data.byte_data;
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.popped_value = '0;
                     rsp_data_in.byte_out     = '0;
                     rsp_data_in.pointer_now  = q_data.pointer_now;
                     rsp_data_in.error        = 1'b0;
                  end
                  bfsp_pkg::CMD_READ: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head_addr;
                     state_in    = ST_READ;
                  end
                  default: begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.popped_value = '0;
                     rsp_data_in.byte_out     = '0;
                     rsp_data_in.pointer_now  = q_data.pointer_now;
                     rsp_data_in.error        = q_data.error;
                  end
               endcase
            end
         end
         ST_MERGE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = base_ff;
            ram_wr_data = (ram_rd_data & ~msk_top) | (win_top & msk_top);
            win_in      = win_ff << BW;
            msk_in      = msk_ff << BW;
            issued_in   = CW'(1);
            if (nbytes_ff == CW'(1)) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.popped_value = '0;
               rsp_data_in.byte_out     = '0;
               rsp_data_in.pointer_now  = ptr_now_ff;
               rsp_data_in.error        = 1'b0;
               state_in                 = ST_IDLE;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            // fresh byte: bits outside the field come out zero
            ram_wr_en = 1'b1;
            win_in    = win_ff << BW;
            msk_in    = msk_ff << BW;
            issued_in = issued_ff + CW'(1);
            if (issued_ff == nbytes_ff - CW'(1)) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.popped_value = '0;
               rsp_data_in.byte_out     = '0;
               rsp_data_in.pointer_now  = ptr_now_ff;
               rsp_data_in.error        = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         ST_POP: begin
            acc_in = acc_next;
            got_in = got_ff + CW'(1);
            if (issued_ff != nbytes_ff) begin
               ram_rd_en = 1'b1;
               issued_in = issued_ff + CW'(1);
            end
            if (got_ff == nbytes_ff - CW'(1)) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.popped_value =
                  bfsp_pkg::VALUE_W'((acc_next >> tail_ff) & pop_mask);
               rsp_data_in.byte_out     = '0;
               rsp_data_in.pointer_now  = ptr_now_ff;
               rsp_data_in.error        = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.popped_value = '0;
            rsp_data_in.byte_out     = ram_rd_data;
            rsp_data_in.pointer_now  = ptr_now_ff;
            rsp_data_in.error        = 1'b0;
            state_in                 = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         nbytes_ff    <= '0;
         issued_ff    <= '0;
         got_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         nbytes_ff    <= nbytes_in;
         issued_ff    <= issued_in;
         got_ff       <= got_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      win_ff      <= win_in;
      msk_ff      <= msk_in;
      acc_ff      <= acc_in;
      tail_ff     <= tail_in;
      count_ff    <= count_in;
      ptr_now_ff  <= ptr_now_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("response during buffer clear");

   a_pop_never_writes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> !ram_wr_en)
      else $error("buffer written during pop");

   a_error_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.error |->
         rsp_data_ff.popped_value == '0 && rsp_data_ff.byte_out == '0)
      else $error("refused request returned data");

endmodule

[hw/rtl/bit_field_stack_packer_top.sv]
// ----------------------------------------------------------------------------
// bit_field_stack_packer_top
// Bit stack over a byte buffer: MSB-first push/pop of 1..32 bit fields.
// ----------------------------------------------------------------------------
//
//   channel   ports                         handshake
//   --------  ----------------------------  ------------------------------
//   request   start, busy, req_data         taken when start && !busy
//   response  rsp_valid, rsp_data           one-cycle strobe, never stalled
//
// The back end's byte loop over the buffer RAM sets the pace, one byte per
// cycle once the command is off the queue. A push spans N bytes (N = 1..5);
// one that starts in an already begun byte reads it while leaving the queue
// and merges it in place. A pop reads its N bytes through the registered RAM
// read port, as does a byte read; a byte write and every refused, pointer-set
// or unknown request is answered from the idle state. The request word passes
// through the command queue before the back end registers its response word.
// Reset: the buffer RAM is cleared one byte a cycle, all BUF_BYTES bytes, with
// busy high. Stalls: busy rises when the two-entry command queue is full.
//
module bit_field_stack_packer_top #(
   parameter int BUF_BYTES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bfsp_pkg::request_type  req_data,
   output logic                   rsp_valid,
   output bfsp_pkg::response_type rsp_data
);

   // front -> queue
   logic                  q_wr;
   bfsp_pkg::command_type q_wr_data;
   logic                  q_full;

   // queue -> back
   logic                  q_valid;
   logic                  q_rd;
   bfsp_pkg::command_type q_rd_data;

   // back -> front: no requests while the buffer is being cleared
   logic                  clearing;

   // Front: checks counts and ranges against the bit pointer, which it owns,
   // so the next word can be checked before the back has touched memory.
   bfsp_front #(
      .BUF_BYTES (BUF_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .clearing  (clearing),
      .q_full    (q_full),
      .q_wr      (q_wr),
      .q_wr_data (q_wr_data)
   );

   bfsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr),
      .wr_data  (q_wr_data),
      .full     (q_full),
      .rd_valid (q_valid),
      .rd_en    (q_rd),
      .rd_data  (q_rd_data)
   );

   // Back: byte-by-byte read/modify/write of the buffer RAM, in queue order.
   bfsp_back #(
      .BUF_BYTES (BUF_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_rd_data),
      .q_rd      (q_rd),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
